// ===== design/fss_pkg.sv =====
// ----------------------------------------------------------------------------
// fss_pkg
// shared constants and types for the fidelity susceptibility stream
// ----------------------------------------------------------------------------
package fss_pkg;

   localparam int VectorLen = 16;
   localparam int IdxW      = $clog2(VectorLen);
   localparam int AccW      = 32 + $clog2(VectorLen);
   localparam int AmpW      = 16;
   localparam int FieldW    = 24;
   localparam int ChiW      = 32;
   localparam int RootW     = (AccW + 24 + 1) / 2;
   localparam int DenW      = 2 * RootW;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EQUAL    = 2'd1,
      ST_ZERONORM = 2'd2,
      ST_SAT      = 2'd3
   } status_type;

   typedef struct packed {
      logic                     start;
      logic signed [AccW-1:0]   dot;
      logic        [AccW-1:0]   norm_prev;
      logic        [AccW-1:0]   norm_cur;
      logic signed [FieldW-1:0] field_prev;
      logic signed [FieldW-1:0] field_cur;
   } job_type;

endpackage

// ===== design/fss_ram.sv =====
// ----------------------------------------------------------------------------
// fss_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module fss_ram #(
   parameter int Width = 16,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end

endmodule

// ===== design/fss_math.sv =====
// ----------------------------------------------------------------------------
// fss_math
// per-row chi computation: two square roots, one long divide, one short divide
// ----------------------------------------------------------------------------
module fss_math (
   input  logic                          clock,
   input  logic                          reset,
   input  fss_pkg::job_type              job,
   output logic                          busy,
   output logic                          done,
   output logic [fss_pkg::ChiW-1:0]      chi,
   output fss_pkg::status_type           status
);

   localparam int RadW = 2 * fss_pkg::RootW;
   localparam int RemW = fss_pkg::RootW + 2;
   localparam int NumW = fss_pkg::AccW + 56;
   localparam int GW   = 34 + 16;
   localparam int D2W  = 2 * fss_pkg::FieldW + 2;

   typedef enum logic [2:0] {
      S_IDLE, S_SQRT_P, S_SQRT_C, S_MUL, S_FDIV, S_GPREP, S_CDIV, S_DONE
   } state_type;

   state_type                   state_ff;
   logic [RadW-1:0]             rad_ff;
   logic [RemW-1:0]             rem_ff;
   logic [fss_pkg::RootW-1:0]   root_ff, rp_ff;
   logic [7:0]                  cnt_ff;
   logic [fss_pkg::AccW-1:0]    normc_ff;
   logic [fss_pkg::DenW-1:0]    den_ff;
   logic [NumW-1:0]             num_ff;
   logic [fss_pkg::DenW:0]      frem_ff;
   logic [33:0]                 fq_ff;
   logic [D2W-1:0]              d2_ff;
   logic [GW-1:0]               gnum_ff;
   logic [D2W:0]                crem_ff;
   logic [GW-1:0]               cq_ff;
   logic [fss_pkg::ChiW-1:0]    chi_ff;
   fss_pkg::status_type         status_ff;

   logic signed [fss_pkg::FieldW:0] dh;
   logic [fss_pkg::AccW-1:0]        absdot;
   logic [RemW-1:0]                 trial;
   logic [RemW-1:0]                 rem_sh;
   logic [fss_pkg::DenW:0]          frem_sh;
   logic [D2W:0]                    crem_sh;
   logic [33:0]                     fq_sat;

   assign dh     = $signed({job.field_prev[fss_pkg::FieldW-1], job.field_prev})
                 - $signed({job.field_cur[fss_pkg::FieldW-1], job.field_cur});
   assign absdot = job.dot[fss_pkg::AccW-1] ? fss_pkg::AccW'(-job.dot)
                                            : fss_pkg::AccW'(job.dot);
   assign rem_sh  = {rem_ff[RemW-3:0], rad_ff[RadW-1 -: 2]};
   assign trial   = rem_sh - {root_ff, 2'b01};
   assign frem_sh = {frem_ff[fss_pkg::DenW-1:0], num_ff[NumW-1]};
   assign crem_sh = {crem_ff[D2W-1:0], gnum_ff[GW-1]};
   assign fq_sat  = (fq_ff > 34'h100000000) ? 34'h100000000 : fq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (job.start) begin
                  d2_ff    <= D2W'(dh * dh);
                  normc_ff <= job.norm_cur;
                  if (dh == '0) begin
                     chi_ff    <= '0;
                     status_ff <= fss_pkg::ST_EQUAL;
                     state_ff  <= S_DONE;
                  end else if (job.norm_prev == '0 || job.norm_cur == '0) begin
                     chi_ff    <= '0;
                     status_ff <= fss_pkg::ST_ZERONORM;
                     state_ff  <= S_DONE;
                  end else begin
                     num_ff   <= {absdot, 56'd0};
                     rad_ff   <= RadW'({job.norm_prev, 24'd0});
                     rem_ff   <= '0;
                     root_ff  <= '0;
                     cnt_ff   <= 8'(fss_pkg::RootW);
                     state_ff <= S_SQRT_P;
                  end
               end
            end
            S_SQRT_P, S_SQRT_C: begin
               rad_ff <= {rad_ff[RadW-3:0], 2'b00};
               if (!trial[RemW-1]) begin
                  rem_ff  <= trial;
                  root_ff <= {root_ff[fss_pkg::RootW-2:0], 1'b1};
               end else begin
                  rem_ff  <= rem_sh;
                  root_ff <= {root_ff[fss_pkg::RootW-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 8'd1;
               if (cnt_ff == 8'd1) begin
                  if (state_ff == S_SQRT_P) begin
                     rp_ff    <= trial[RemW-1] ? {root_ff[fss_pkg::RootW-2:0], 1'b0}
                                               : {root_ff[fss_pkg::RootW-2:0], 1'b1};
                     rad_ff   <= RadW'({normc_ff, 24'd0});
                     rem_ff   <= '0;
                     root_ff  <= '0;
                     cnt_ff   <= 8'(fss_pkg::RootW);
                     state_ff <= S_SQRT_C;
                  end else begin
                     state_ff <= S_MUL;
                  end
               end
            end
            S_MUL: begin
               den_ff   <= fss_pkg::DenW'(rp_ff * root_ff);
               frem_ff  <= '0;
               fq_ff    <= '0;
               cnt_ff   <= 8'(NumW);
               state_ff <= S_FDIV;
            end
            S_FDIV: begin
               num_ff <= {num_ff[NumW-2:0], 1'b0};
               if (frem_sh >= {1'b0, den_ff}) begin
                  frem_ff <= frem_sh - {1'b0, den_ff};
                  fq_ff   <= (fq_ff > 34'h100000000) ? fq_ff : {fq_ff[32:0], 1'b1};
               end else begin
                  frem_ff <= frem_sh;
                  fq_ff   <= (fq_ff > 34'h100000000) ? fq_ff : {fq_ff[32:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 8'd1;
               if (cnt_ff == 8'd1) begin
                  state_ff <= S_GPREP;
               end
            end
            S_GPREP: begin
               gnum_ff  <= GW'({(34'h200000000 - {fq_sat[32:0], 1'b0}), 16'd0});
               cnt_ff   <= 8'(GW);
               crem_ff  <= '0;
               cq_ff    <= '0;
               state_ff <= S_CDIV;
            end
            S_CDIV: begin
               gnum_ff <= {gnum_ff[GW-2:0], 1'b0};
               if (crem_sh >= {1'b0, d2_ff}) begin
                  crem_ff <= crem_sh - {1'b0, d2_ff};
                  cq_ff   <= {cq_ff[GW-2:0], 1'b1};
               end else begin
                  crem_ff <= crem_sh;
                  cq_ff   <= {cq_ff[GW-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 8'd1;
               if (cnt_ff == 8'd1) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // chi formed in the cycle after the final divide step
   logic pend_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= (state_ff == S_CDIV && cnt_ff == 8'd1);
      end
   end

   logic [fss_pkg::ChiW-1:0] chi_out;
   fss_pkg::status_type      st_out;
   always_comb begin
      chi_out = chi_ff;
      st_out  = status_ff;
      if (pend_ff) begin
         if (cq_ff[GW-1:fss_pkg::ChiW] != '0) begin
            chi_out = '1;
            st_out  = fss_pkg::ST_SAT;
         end else begin
            chi_out = cq_ff[fss_pkg::ChiW-1:0];
            st_out  = fss_pkg::ST_OK;
         end
      end
   end

   assign busy   = (state_ff != S_IDLE);
   assign done   = (state_ff == S_DONE);
   assign chi    = chi_out;
   assign status = st_out;

`ifndef SYNTHESIS
   ap_start_idle: assert property (@(posedge clock) disable iff (reset)
      job.start |-> state_ff == S_IDLE)
      else $error("job started while busy");
   ap_done_once: assert property (@(posedge clock) disable iff (reset)
      done |=> !done)
      else $error("done held twice");
   ap_pend_done: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> done)
      else $error("divide result outside done");
`endif

endmodule

// ===== design/fidelity_susceptibility_stream.sv =====
// ----------------------------------------------------------------------------
// fidelity_susceptibility_stream
// fidelity susceptibility of consecutive state vectors, finite difference
// ----------------------------------------------------------------------------
// req_ channel: one amplitude per transfer with the row field value and a
// new-set flag; a row is VectorLen transfers, the field taken on the first.
// previous row amplitudes sit in a small ram, read in the transfer cycle
// and rewritten with the current amplitude; each element is a ram read, then
// an accumulate and write back, before the next element is taken.
// rsp_ channel: one transfer at the end of each row that has a predecessor
// in its set. The last element hands the row to a sequential math unit
// (two bit-per-cycle square roots, a 92-step divide and a 50-step divide)
// once the output register is free; req_ready stays low while it runs.
// result waits in an output register; while the receiver stalls, new
// elements of the following row are still taken until that row's end.
// reset clears all control state; ram contents need no clearing.
// ----------------------------------------------------------------------------
module fidelity_susceptibility_stream (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [fss_pkg::FieldW-1:0]  req_field_value,
   input  logic signed [fss_pkg::AmpW-1:0]    req_amplitude,
   input  logic                               req_first_of_set,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [fss_pkg::FieldW-1:0]  rsp_lower_field,
   output logic        [fss_pkg::ChiW-1:0]    rsp_chi_value,
   output logic        [1:0]                  rsp_status
);

   typedef enum logic [1:0] {P_READ, P_ACC, P_WAIT} phase_type;

   phase_type                         phase_ff;
   logic signed [fss_pkg::FieldW-1:0] fld_ff, cur_field_ff, prev_field_ff;
   logic signed [fss_pkg::AmpW-1:0]   amp_ff;
   logic                              first_ff;
   logic [fss_pkg::IdxW-1:0]          idx_ff;
   logic                              have_prev_ff;
   logic signed [fss_pkg::AccW-1:0]   dot_ff;
   logic [fss_pkg::AccW-1:0]          norm_ff, prev_norm_ff;
   logic                              out_valid_ff;
   logic signed [fss_pkg::FieldW-1:0] out_field_ff;
   logic [fss_pkg::ChiW-1:0]          out_chi_ff;
   logic [1:0]                        out_status_ff;
   logic signed [fss_pkg::FieldW-1:0] job_field_ff;

   logic [fss_pkg::IdxW-1:0]          idx_in;
   logic [fss_pkg::AmpW-1:0]          ram_rd;
   logic                              hp_in;
   logic signed [fss_pkg::AccW-1:0]   dot_base, dot_in;
   logic [fss_pkg::AccW-1:0]          norm_base, norm_in;
   logic signed [2*fss_pkg::AmpW-1:0] prod_dot, prod_sq;
   logic                              row_end;
   fss_pkg::job_type                  job;
   logic                              m_busy, m_done;
   logic [fss_pkg::ChiW-1:0]          m_chi;
   fss_pkg::status_type               m_status;

   logic req_xfer;
   assign req_xfer  = req_valid && req_ready;
   assign req_ready = (phase_ff == P_READ) && !m_busy && !job.start;

   assign idx_in = req_first_of_set ? '0 : idx_ff;

   fss_ram #(.Width(fss_pkg::AmpW), .Depth(fss_pkg::VectorLen)) u_row (
      .clock   (clock),
      .wr_en   (phase_ff == P_ACC),
      .addr    ((phase_ff == P_ACC) ? idx_ff : idx_in),
      .wr_data (amp_ff),
      .rd_data (ram_rd)
   );

   assign hp_in     = first_ff ? 1'b0 : have_prev_ff;
   assign prod_dot  = amp_ff * $signed(ram_rd);
   assign prod_sq   = amp_ff * amp_ff;
   assign dot_base  = (idx_ff == '0) ? '0 : dot_ff;
   assign norm_base = (idx_ff == '0) ? '0 : norm_ff;
   assign dot_in    = hp_in ? dot_base + fss_pkg::AccW'(prod_dot) : dot_base;
   assign norm_in   = norm_base + fss_pkg::AccW'($unsigned(prod_sq));
   assign row_end   = (phase_ff == P_ACC) && (idx_ff == fss_pkg::IdxW'(fss_pkg::VectorLen-1));

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= P_READ;
         idx_ff       <= '0;
         have_prev_ff <= 1'b0;
         job.start    <= 1'b0;
         out_valid_ff <= 1'b0;
         cur_field_ff <= '0;
         prev_field_ff <= '0;
         prev_norm_ff <= '0;
         dot_ff       <= '0;
         norm_ff      <= '0;
      end else begin
         job.start <= 1'b0;
         if (rsp_valid && rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (m_done) begin
            out_valid_ff  <= 1'b1;
            out_field_ff  <= job_field_ff;
            out_chi_ff    <= m_chi;
            out_status_ff <= m_status;
         end
         case (phase_ff)
            P_READ: begin
               if (req_xfer) begin
                  amp_ff   <= req_amplitude;
                  fld_ff   <= req_field_value;
                  first_ff <= req_first_of_set;
                  idx_ff   <= idx_in;
                  phase_ff <= P_ACC;
               end
            end
            P_ACC: begin
               have_prev_ff <= hp_in;
               dot_ff       <= dot_in;
               norm_ff      <= norm_in;
               if (idx_ff == '0) begin
                  cur_field_ff <= fld_ff;
               end
               idx_ff   <= idx_ff + 1'b1;
               phase_ff <= P_READ;
               if (row_end) begin
                  idx_ff        <= '0;
                  have_prev_ff  <= 1'b1;
                  prev_norm_ff  <= norm_in;
                  prev_field_ff <= (idx_ff == '0) ? fld_ff : cur_field_ff;
                  if (hp_in) begin
                     job.dot        <= dot_in;
                     job.norm_prev  <= prev_norm_ff;
                     job.norm_cur   <= norm_in;
                     job.field_prev <= prev_field_ff;
                     job.field_cur  <= cur_field_ff;
                     job_field_ff   <= prev_field_ff;
                     phase_ff       <= P_WAIT;
                  end
               end
            end
            P_WAIT: begin
               // start the math only once the result register is free
               if (!out_valid_ff || (rsp_valid && rsp_ready)) begin
                  job.start <= 1'b1;
                  phase_ff  <= P_READ;
               end
            end
            default: phase_ff <= P_READ;
         endcase
      end
   end

   fss_math u_math (
      .clock  (clock),
      .reset  (reset),
      .job    (job),
      .busy   (m_busy),
      .done   (m_done),
      .chi    (m_chi),
      .status (m_status)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_lower_field = out_field_ff;
   assign rsp_chi_value   = out_chi_ff;
   assign rsp_status      = out_status_ff;

`ifndef SYNTHESIS
   ap_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      m_done |-> !out_valid_ff || (rsp_valid && rsp_ready))
      else $error("result register overwritten");
   ap_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !m_busy)
      else $error("transfer taken while math busy");
   ap_acc_follows: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> phase_ff == P_ACC)
      else $error("accumulate step missed");
`endif

endmodule

// ===== tb/fss_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fss_checker
// watches both channels of the fidelity susceptibility stream, predicts the
// susceptibility of each completed row pair and compares every rsp_ transfer
// ----------------------------------------------------------------------------
module fss_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic signed [fss_pkg::FieldW-1:0] req_field_value,
   input  logic signed [fss_pkg::AmpW-1:0]   req_amplitude,
   input  logic                              req_first_of_set,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [fss_pkg::FieldW-1:0] rsp_lower_field,
   input  logic        [fss_pkg::ChiW-1:0]   rsp_chi_value,
   input  logic        [1:0]                 rsp_status,
   output int                                errors,
   output int                                pending,
   output int                                results_seen
);

   typedef struct {
      logic signed [fss_pkg::FieldW-1:0] lower_field;
      logic        [fss_pkg::ChiW-1:0]   chi;
      fss_pkg::status_type               status;
   } chi_result_type;

   chi_result_type chi_queue[$];

   logic signed [fss_pkg::AmpW-1:0] row_mem [fss_pkg::VectorLen];
   longint unsigned prev_norm;
   longint          prev_field;
   longint          cur_field;
   longint          dot_acc;
   longint unsigned norm_acc;
   int              elem_idx;
   bit              have_prev;

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic chi_result_type predict_chi();
      chi_result_type  r;
      longint          dh;
      longint unsigned d2, den, absdot, q, rem, g, chi, cap;
      r.lower_field = prev_field[fss_pkg::FieldW-1:0];
      r.chi         = '0;
      dh = prev_field - cur_field;
      d2 = dh * dh;
      cap = 64'd1 << 32;
      if (d2 == 0) begin
         r.status = fss_pkg::ST_EQUAL;
      end else if (prev_norm == 0 || norm_acc == 0) begin
         r.status = fss_pkg::ST_ZERONORM;
      end else begin
         den    = int_sqrt(prev_norm << 24) * int_sqrt(norm_acc << 24);
         absdot = (dot_acc < 0) ? -dot_acc : dot_acc;
         q   = absdot / den;
         rem = absdot % den;
         if (q > cap) q = cap;
         else begin
            for (int i = 0; i < 56; i++) begin
               rem = rem << 1;
               q   = q << 1;
               if (rem >= den) begin
                  rem = rem - den;
                  q   = q | 1;
               end
               if (q > cap) begin
                  q = cap;
                  break;
               end
            end
         end
         g   = (64'd1 << 33) - 2 * q;
         chi = (g << 16) / d2;
         r.status = fss_pkg::ST_OK;
         if (chi > 64'hFFFF_FFFF) begin
            chi      = 64'hFFFF_FFFF;
            r.status = fss_pkg::ST_SAT;
         end
         r.chi = chi[31:0];
      end
      return r;
   endfunction

   assign pending = chi_queue.size();

   always @(posedge clock) begin
      chi_result_type  exp_r;
      longint          amp;
      if (reset) begin
         prev_norm  = 0;
         prev_field = 0;
         cur_field  = 0;
         dot_acc    = 0;
         norm_acc   = 0;
         elem_idx   = 0;
         have_prev  = 0;
         errors       <= 0;
         results_seen <= 0;
         chi_queue.delete();
      end else begin
         // result side first, so a transfer sees only earlier expectations
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (chi_queue.size() == 0) begin
               $display("%0t: unexpected result field=%0d chi=%h status=%0d",
                        $time, rsp_lower_field, rsp_chi_value, rsp_status);
               errors <= errors + 1;
            end else begin
               exp_r = chi_queue.pop_front();
               if (rsp_lower_field !== exp_r.lower_field ||
                   rsp_chi_value !== exp_r.chi || rsp_status !== exp_r.status) begin
                  $display("%0t: mismatch expected field=%0d chi=%h status=%0d",
                           $time, exp_r.lower_field, exp_r.chi, exp_r.status);
                  $display("%0t:            actual field=%0d chi=%h status=%0d",
                           $time, rsp_lower_field, rsp_chi_value, rsp_status);
                  errors <= errors + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            amp = req_amplitude;
            if (req_first_of_set) begin
               have_prev = 0;
               elem_idx  = 0;
            end
            if (elem_idx == 0) begin
               cur_field = req_field_value;
               dot_acc   = 0;
               norm_acc  = 0;
            end
            if (have_prev) dot_acc += amp * longint'(row_mem[elem_idx]);
            norm_acc += amp * amp;
            row_mem[elem_idx] = req_amplitude;
            elem_idx++;
            if (elem_idx == fss_pkg::VectorLen) begin
               elem_idx = 0;
               if (have_prev) chi_queue.insert(chi_queue.size(), predict_chi());
               have_prev  = 1;
               prev_norm  = norm_acc;
               prev_field = cur_field;
            end
         end
      end
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the fidelity susceptibility stream: directed
// extreme rows, then random sets of sorted rows with noise, random stalls on
// both channels and one long receiver hold-off
// ----------------------------------------------------------------------------
module testbench;

   localparam int CycleLimit = 600000;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic signed [fss_pkg::FieldW-1:0] req_field_value;
   logic signed [fss_pkg::AmpW-1:0]   req_amplitude;
   logic                              req_first_of_set;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic signed [fss_pkg::FieldW-1:0] rsp_lower_field;
   logic        [fss_pkg::ChiW-1:0]   rsp_chi_value;
   logic        [1:0]                 rsp_status;

   int  errors, pending, results_seen;
   int  items_sent;
   int  cycles;
   bit  no_idle;
   bit  hold_request;
   int  hold_count;
   logic signed [fss_pkg::AmpW-1:0] last_row [fss_pkg::VectorLen];

   fidelity_susceptibility_stream u_dut (.*);

   fss_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_field_value, .req_amplitude,
      .req_first_of_set, .rsp_valid, .rsp_ready, .rsp_lower_field, .rsp_chi_value,
      .rsp_status, .errors, .pending, .results_seen
   );

   initial clock = 0;
   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_ready  = 0;
      hold_count = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_count   = 2000;
            hold_request = 0;
         end
         if (hold_count > 0) begin
            hold_count--;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 26);
         end
      end
   end

   task automatic send_element(logic signed [fss_pkg::FieldW-1:0] field,
                               logic signed [fss_pkg::AmpW-1:0] amp, logic first);
      if (!no_idle && $urandom_range(0, 99) < 26) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid        <= 1;
      req_field_value  <= field;
      req_amplitude    <= amp;
      req_first_of_set <= first;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // one row; kind 0 random, 1 near previous, 2 zero, 3 extremes
   task automatic send_row(logic signed [fss_pkg::FieldW-1:0] field, logic first,
                           int kind);
      logic signed [fss_pkg::AmpW-1:0] amp;
      int                              delta;
      for (int j = 0; j < fss_pkg::VectorLen; j++) begin
         case (kind)
            0: amp = fss_pkg::AmpW'($urandom);
            1: begin
               delta = $urandom_range(0, 200) - 100;
               amp   = fss_pkg::AmpW'(last_row[j] + delta);
            end
            2: amp = 0;
            default: amp = (j % 2) ? 16'sh7FFF : -16'sh8000;
         endcase
         last_row[j] = amp;
         send_element(field, amp, first && j == 0);
      end
   endtask

   initial begin
      logic signed [fss_pkg::FieldW-1:0] field;
      int                                rows, kind, step, span;
      bit                                hold_done;
      reset            = 1;
      req_valid        = 0;
      req_field_value  = '0;
      req_amplitude    = '0;
      req_first_of_set = 0;
      no_idle          = 0;
      hold_request     = 0;
      hold_done        = 0;
      items_sent       = 0;
      cycles           = 0;
      foreach (last_row[j]) last_row[j] = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extreme fields and amplitudes, a zero-norm row on equal fields,
      // saturation on a tiny field step, and a new set in mid-row
      send_row(-24'sh800000, 1, 3);
      send_row(24'sh7FFFFF, 0, 3);
      send_row(24'sh7FFFFF, 0, 2);
      send_row(24'sh000010, 1, 0);
      send_row(24'sh000011, 0, 1);
      for (int j = 0; j < 5; j++) send_element(24'sh000100, fss_pkg::AmpW'($urandom), 0);
      send_row(24'sh000200, 1, 0);
      send_row(24'sh010200, 0, 1);

      // random sets of sorted rows
      while (items_sent < 1400) begin
         if (items_sent > 300 && !hold_done) begin
            hold_request = 1;
            hold_done    = 1;
         end
         no_idle = (items_sent > 700 && items_sent < 900);
         field = fss_pkg::FieldW'($urandom);
         rows  = $urandom_range(2, 6);
         span  = $urandom_range(0, 22);
         for (int r = 0; r < rows; r++) begin
            kind = $urandom_range(0, 99);
            kind = (kind < 10) ? 0 : (kind < 15) ? 2 : (kind < 18) ? 3 : 1;
            if (r == 0 && kind == 1) kind = 0;
            send_row(field, r == 0, kind);
            step = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 1 << span);
            if (int'(field) + step <= 8388607) field = fss_pkg::FieldW'(field + step);
            // broken row: a new set starts part way through
            if ($urandom_range(0, 29) == 0) begin
               repeat ($urandom_range(1, fss_pkg::VectorLen - 1))
                  send_element(fss_pkg::FieldW'($urandom), fss_pkg::AmpW'($urandom), 0);
               break;
            end
         end
      end
      req_valid <= 0;
      no_idle = 0;

      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      $display("covered %0d input transfers and %0d result transfers",
               items_sent, results_seen);
      if (errors == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
